@@ hdl/ttip_pkg.sv @@
// ----------------------------------------------------------------------------
// ttip_pkg: shared types and constants of the text to integer parser
// Field widths, character codes, parse phases and the byte decode functions.
// ----------------------------------------------------------------------------
`default_nettype none

package ttip_pkg;

   // field widths
   localparam int CH_W    = 8;
   localparam int BASE_W  = 6;
   localparam int VALUE_W = 64;
   localparam int STOP_W  = 13;

   // default length limit of one conversion
   localparam int TTIP_MAX_LEN = 4096;

   // radix values
   localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
   localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
   localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
   localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
   localparam logic [BASE_W-1:0] DIGIT_NONE = 6'd63;

   // character codes
   localparam logic [CH_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CH_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CH_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CH_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CH_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CH_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CH_W-1:0] CHAR_UP_A  = 8'h41;
   localparam logic [CH_W-1:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [CH_W-1:0] CHAR_LO_A  = 8'h61;
   localparam logic [CH_W-1:0] CHAR_LO_Z  = 8'h7A;
   localparam logic [CH_W-1:0] CHAR_UP_X  = 8'h58;
   localparam logic [CH_W-1:0] CHAR_LO_X  = 8'h78;
   localparam logic [CH_W-1:0] CHAR_TEN   = 8'd10;

   // parse phase, one-hot
   typedef enum logic [5:0] {
      PH_IDLE    = 6'b000001,
      PH_LEAD    = 6'b000010,
      PH_PREFIX  = 6'b000100,
      PH_ZERO    = 6'b001000,
      PH_HEXNEED = 6'b010000,
      PH_DIGITS  = 6'b100000
   } phase_type;

   // one input item as held in the input register
   typedef struct packed {
      logic [CH_W-1:0] ch;
      logic            start_req;
   } item_type;

   // digit value of a byte, DIGIT_NONE for anything that is not alphanumeric
   function automatic logic [BASE_W-1:0] ttip_digit(input logic [CH_W-1:0] c);
      logic [CH_W-1:0] d;
      d = CH_W'(DIGIT_NONE);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = c - CHAR_ZERO;
      end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
         d = c - CHAR_UP_A + CHAR_TEN;
      end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
         d = c - CHAR_LO_A + CHAR_TEN;
      end
      return d[BASE_W-1:0];
   endfunction

   // space, tab, LF, VT, FF, CR
   function automatic logic ttip_is_blank(input logic [CH_W-1:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

endpackage

`default_nettype wire

@@ hdl/ttip_req_if.sv @@
// ----------------------------------------------------------------------------
// ttip_req_if: input byte channel
// Valid/ready channel that carries one text byte and the start flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttip_req_if;
   import ttip_pkg::*;

   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;
   logic            start_req;

   modport source (output valid, output ch, output start_req, input ready);
   modport sink   (input valid, input ch, input start_req, output ready);

endinterface

`default_nettype wire

@@ hdl/ttip_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ttip_rsp_if: result channel
// Valid/ready channel that carries the converted value and the stop offset.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttip_rsp_if;
   import ttip_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic [STOP_W-1:0]         stop_offset;

   modport source (output valid, output value, output stop_offset, input ready);
   modport sink   (input valid, input value, input stop_offset, output ready);

endinterface

`default_nettype wire

@@ hdl/ttip_in_stage.sv @@
// ----------------------------------------------------------------------------
// ttip_in_stage: input register
// Captures one byte item per cycle while the core takes them, and holds each until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ttip_in_stage (
   input  wire logic           clock,
   input  wire logic           reset,
   ttip_req_if.sink            req,
   output ttip_pkg::item_type  item,
   output logic                item_valid,
   input  wire logic           item_take
);
   import ttip_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // accept when empty or when the held item leaves this cycle
   assign req.ready = !valid_ff || item_take;

   // hold the flag until the item is taken
   always_comb begin
      valid_in = valid_ff;
      if (req.ready) begin
         valid_in = req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // load payload on accept
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         item_ff.ch        <= req.ch;
         item_ff.start_req <= req.start_req;
      end
   end

   assign item       = item_ff;
   assign item_valid = valid_ff;

endmodule

`default_nettype wire

@@ hdl/ttip_core.sv @@
// ----------------------------------------------------------------------------
// ttip_core: parse step and result register
// Applies one byte to the conversion state and registers the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module ttip_core #(
   parameter int MAX_LEN = ttip_pkg::TTIP_MAX_LEN
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [ttip_pkg::BASE_W-1:0] csr_wr_data,
   input  wire ttip_pkg::item_type          item,
   input  wire logic                        item_valid,
   output logic                             item_take,
   ttip_rsp_if.source                       rsp
);
   import ttip_pkg::*;

   localparam int PW = $clog2(MAX_LEN + 1);
   localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_LEN);

   // configuration and conversion state
   logic [BASE_W-1:0]  number_base_ff;
   phase_type          phase_ff,  phase_in;
   logic [VALUE_W-1:0] acc_ff,    acc_in;
   logic               neg_ff,    neg_in;
   logic [BASE_W-1:0]  base_ff,   base_in;
   logic [PW-1:0]      pos_ff,    pos_in;
   logic [PW-1:0]      endo_ff,   endo_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STOP_W-1:0]  rsp_stop_ff,  rsp_stop_in;

   logic               emit;
   logic               done;
   logic               out_free;
   logic [BASE_W-1:0]  dig;
   logic               blank;
   logic [PW-1:0]      pos_adv;
   logic [VALUE_W-1:0] acc_start;

   // step when an item is held and the result slot can take a result
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign item_take = item_valid && out_free;

   assign dig   = ttip_digit(item.ch);
   assign blank = ttip_is_blank(item.ch);

   // saturating advance from the position this byte starts at
   always_comb begin
      logic [PW-1:0] p;
      p         = item.start_req ? '0 : pos_ff;
      pos_adv   = (p < POS_LIMIT) ? p + PW'(1) : p;
      acc_start = item.start_req ? '0 : acc_ff;
   end

   // one byte through the phases, falling through where the byte is not used
   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_start;
      neg_in   = neg_ff;
      base_in  = base_ff;
      pos_in   = pos_ff;
      endo_in  = endo_ff;
      emit     = 1'b0;
      done     = 1'b0;

      if (item.start_req) begin
         phase_in = PH_LEAD;
         neg_in   = 1'b0;
         pos_in   = '0;
         endo_in  = '0;
         base_in  = number_base_ff;
         if (number_base_ff == BASE_ONE || number_base_ff > BASE_MAX) begin
            emit = 1'b1;
            done = 1'b1;
         end
      end
      if (phase_in == PH_IDLE) begin
         done = 1'b1;
      end

      // skip blanks, take a sign
      if (!done && phase_in == PH_LEAD) begin
         if (blank) begin
            pos_in = pos_adv;
            done   = 1'b1;
         end else if (item.ch == CHAR_MINUS || item.ch == CHAR_PLUS) begin
            neg_in   = (item.ch == CHAR_MINUS);
            pos_in   = pos_adv;
            phase_in = PH_PREFIX;
            done     = 1'b1;
         end else begin
            phase_in = PH_PREFIX;
         end
      end

      // leading zero of a possible hex or octal prefix
      if (!done && phase_in == PH_PREFIX) begin
         if (item.ch == CHAR_ZERO && (base_in == BASE_AUTO || base_in == BASE_HEX)) begin
            acc_in   = '0;
            pos_in   = pos_adv;
            endo_in  = pos_adv;
            phase_in = PH_ZERO;
            done     = 1'b1;
         end else begin
            if (base_in == BASE_AUTO) begin
               base_in = BASE_DEC;
            end
            phase_in = PH_DIGITS;
         end
      end

      // x after the zero
      if (!done && phase_in == PH_ZERO) begin
         if (item.ch == CHAR_LO_X || item.ch == CHAR_UP_X) begin
            pos_in   = pos_adv;
            base_in  = BASE_HEX;
            phase_in = PH_HEXNEED;
            done     = 1'b1;
         end else begin
            if (base_in == BASE_AUTO) begin
               base_in = BASE_OCT;
            end
            phase_in = PH_DIGITS;
         end
      end

      // a hex digit must follow the prefix
      if (!done && phase_in == PH_HEXNEED) begin
         if (dig < BASE_HEX) begin
            phase_in = PH_DIGITS;
         end else begin
            emit = 1'b1;
            done = 1'b1;
         end
      end

      // accumulate a digit or stop
      if (!done) begin
         if (dig < base_in) begin
            acc_in  = acc_start * VALUE_W'(base_in) + VALUE_W'(dig);
            pos_in  = pos_adv;
            endo_in = pos_adv;
         end else begin
            emit = 1'b1;
         end
      end

      if (emit) begin
         phase_in = PH_IDLE;
      end
   end

   // result formed from the state left by this byte
   always_comb begin
      rsp_value_in = neg_in ? ('0 - acc_in) : acc_in;
      rsp_stop_in  = STOP_W'(endo_in);
      rsp_valid_in = rsp_valid_ff;
      if (item_take && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // advance the state on each step
   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= BASE_DEC;
         phase_ff       <= PH_IDLE;
         acc_ff         <= '0;
         neg_ff         <= 1'b0;
         base_ff        <= BASE_DEC;
         pos_ff         <= '0;
         endo_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            number_base_ff <= csr_wr_data;
         end
         if (item_take) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            neg_ff   <= neg_in;
            base_ff  <= base_in;
            pos_ff   <= pos_in;
            endo_ff  <= endo_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load result payload
   always_ff @(posedge clock) begin
      if (item_take && emit) begin
         rsp_value_ff <= rsp_value_in;
         rsp_stop_ff  <= rsp_stop_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.value       = $signed(rsp_value_ff);
   assign rsp.stop_offset = rsp_stop_ff;

`ifndef SYNTH
   a_result_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(item_take))
      else $error("result appeared without a parse step");

   a_pos_limit: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LIMIT)
      else $error("position beyond length limit");

   a_end_behind_pos: assert property (@(posedge clock) disable iff (reset)
      endo_ff <= pos_ff)
      else $error("end offset ahead of position");

   a_bad_base: assert property (@(posedge clock) disable iff (reset)
      item_take && item.start_req && (number_base_ff == BASE_ONE || number_base_ff > BASE_MAX)
      |=> rsp_valid_ff && rsp_value_ff == '0 && rsp_stop_ff == '0 && phase_ff == PH_IDLE)
      else $error("invalid radix did not give an empty result");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      item_take && !item.start_req && phase_ff == PH_IDLE |=> $stable(acc_ff))
      else $error("accumulator changed on an idle byte");
`endif

endmodule

`default_nettype wire

@@ hdl/text_to_integer_parser.sv @@
// ----------------------------------------------------------------------------
// text_to_integer_parser: streaming text to integer converter
// Converts a byte stream to a signed 64-bit integer with strtol rules.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one text byte per item; start_req marks the first byte
//   of a conversion. Blanks, an optional sign and the radix prefix are
//   handled as strtol does; digits accumulate modulo 2^64. The first byte
//   that ends the number (NUL included) yields one rsp_bus item with the
//   value and the offset where parsing stopped. Later bytes are dropped
//   until the next start.
//   csr_wr_en/csr_wr_data set the radix (0 auto, 2 to 36); it is sampled on
//   each start byte and must only change while the block is idle.
// Timing:
//   One byte per cycle sustained while rsp_bus is not stalled; each byte
//   passes through the accumulator multiply-add. rsp_bus.valid rises once
//   the byte that ends the number has passed the input register and then
//   the result register; a stalled result can hold it between the two.
// Reset and stall:
//   Reset empties both registers, clears the conversion and sets radix 10.
//   A stalled result holds the core; one more byte waits in the input
//   register, then req_bus.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module text_to_integer_parser #(
   parameter int MAX_LEN = ttip_pkg::TTIP_MAX_LEN
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [ttip_pkg::BASE_W-1:0] csr_wr_data,
   ttip_req_if.sink                         req_bus,
   ttip_rsp_if.source                       rsp_bus
);
   import ttip_pkg::*;

   item_type item;
   logic     item_valid;
   logic     item_take;

   // hold one incoming byte
   ttip_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .item       (item),
      .item_valid (item_valid),
      .item_take  (item_take)
   );

   // parse and register results
   ttip_core #(
      .MAX_LEN (MAX_LEN)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item        (item),
      .item_valid  (item_valid),
      .item_take   (item_take),
      .rsp         (rsp_bus)
   );

endmodule

`default_nettype wire

@@ tb/ttip_check_pkg.sv @@
// ----------------------------------------------------------------------------
// ttip_check_pkg: expected-number tracking for the text to integer parser
// Predicts each conversion result from the accepted bytes and the radix
// register, then compares what the block returns against the oldest
// prediction.
// ----------------------------------------------------------------------------
package ttip_check_pkg;
   import ttip_pkg::*;

   // one converted number as the result channel carries it
   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic [STOP_W-1:0]         stop_offset;
   } number_type;

   class conversion_board;
      number_type expected_numbers[$];
      int unsigned failures;
      int unsigned numbers_checked;

      // mirror of the register and of the conversion in progress
      logic [BASE_W-1:0]  radix;
      logic [BASE_W-1:0]  active_base;
      phase_type          phase;
      logic [VALUE_W-1:0] acc;
      logic               negate;
      int unsigned        position;
      int unsigned        end_pos;

      function new();
         radix           = BASE_DEC;
         active_base     = BASE_DEC;
         phase           = PH_IDLE;
         acc             = '0;
         negate          = 1'b0;
         position        = 0;
         end_pos         = 0;
         failures        = 0;
         numbers_checked = 0;
      endfunction

      function void set_radix(logic [BASE_W-1:0] b);
         radix = b;
      endfunction

      function int unsigned pending();
         return expected_numbers.size();
      endfunction

      // alphanumeric value of a byte, 63 for anything else
      function int unsigned digit_of(logic [CH_W-1:0] c);
         if (c >= CHAR_ZERO && c <= CHAR_NINE) return c - CHAR_ZERO;
         if (c >= CHAR_UP_A && c <= CHAR_UP_Z) return c - CHAR_UP_A + 10;
         if (c >= CHAR_LO_A && c <= CHAR_LO_Z) return c - CHAR_LO_A + 10;
         return DIGIT_NONE;
      endfunction

      function bit is_space(logic [CH_W-1:0] c);
         return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
      endfunction

      // advance the byte offset, saturating at the length limit
      function void bump();
         if (position < TTIP_MAX_LEN) position++;
      endfunction

      // close the conversion and queue its number
      function void finish_number();
         number_type n;
         n.value       = negate ? 64'd0 - acc : acc;
         n.stop_offset = end_pos[STOP_W-1:0];
         expected_numbers.push_back(n);
         phase = PH_IDLE;
      endfunction

      // predict the effect of one accepted byte
      function void note_byte(logic [CH_W-1:0] c, logic first);
         int unsigned d;
         if (first) begin
            phase       = PH_LEAD;
            acc         = '0;
            negate      = 1'b0;
            position    = 0;
            end_pos     = 0;
            active_base = radix;
            if (active_base == BASE_ONE || active_base > BASE_MAX) begin
               finish_number();
               return;
            end
         end
         if (phase == PH_IDLE) return;
         d = digit_of(c);
         // leading blanks and sign
         if (phase == PH_LEAD) begin
            if (is_space(c)) begin
               bump();
               return;
            end
            if (c == CHAR_MINUS || c == CHAR_PLUS) begin
               negate = (c == CHAR_MINUS);
               bump();
               phase = PH_PREFIX;
               return;
            end
            phase = PH_PREFIX;
         end
         // a leading zero may open a radix prefix
         if (phase == PH_PREFIX) begin
            if (c == CHAR_ZERO && (active_base == BASE_AUTO || active_base == BASE_HEX)) begin
               acc = '0;
               bump();
               end_pos = position;
               phase   = PH_ZERO;
               return;
            end
            if (active_base == BASE_AUTO) active_base = BASE_DEC;
            phase = PH_DIGITS;
         end
         if (phase == PH_ZERO) begin
            if (c == CHAR_LO_X || c == CHAR_UP_X) begin
               bump();
               active_base = BASE_HEX;
               phase       = PH_HEXNEED;
               return;
            end
            if (active_base == BASE_AUTO) active_base = BASE_OCT;
            phase = PH_DIGITS;
         end
         // after 0x a hex digit must follow, else only the zero counts
         if (phase == PH_HEXNEED) begin
            if (d >= 16) begin
               finish_number();
               return;
            end
            phase = PH_DIGITS;
         end
         if (d < active_base) begin
            acc = acc * 64'(active_base) + 64'(d);
            bump();
            end_pos = position;
            return;
         end
         finish_number();
      endfunction

      function void report(string what, logic signed [VALUE_W-1:0] want,
                           logic signed [VALUE_W-1:0] got);
         failures++;
         if (failures <= 10)
            $display("MISMATCH %s: expected %0d (0x%h), got %0d (0x%h)",
                     what, want, want, got, got);
      endfunction

      // compare one returned number with the oldest prediction
      function void check_result(logic signed [VALUE_W-1:0] value,
                                 logic [STOP_W-1:0] stop_offset);
         number_type n;
         if (expected_numbers.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("MISMATCH unexpected number %0d, offset %0d", value, stop_offset);
            return;
         end
         n = expected_numbers.pop_front();
         numbers_checked++;
         if (value !== n.value) report("value", n.value, value);
         if (stop_offset !== n.stop_offset)
            report("stop_offset", n.stop_offset, stop_offset);
      endfunction
   endclass

endpackage

@@ tb/text_to_integer_parser_test.sv @@
// ----------------------------------------------------------------------------
// text_to_integer_parser_test: testbench of the text to integer parser
// Feeds directed strings and random well-formed, broken and noisy byte
// streams under several radix settings, with random idling on both
// channels and one long result stall, and checks every returned number
// against a cycle-free prediction.
// ----------------------------------------------------------------------------
module text_to_integer_parser_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ttip_pkg::*;
   import ttip_check_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 6;
   localparam int HOLD_CYCLES  = 80;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [BASE_W-1:0] csr_wr_data = '0;

   ttip_req_if req_bus ();
   ttip_rsp_if rsp_bus ();

   conversion_board board = new();

   bit          steady = 1'b0;
   bit          hold_request = 1'b0;
   int          hold_left = 0;
   int unsigned cycles = 0;
   int unsigned bytes_sent = 0;
   int unsigned radix_writes = 0;

   text_to_integer_parser uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d numbers pending", cycles, board.pending());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side: random stalls, one long hold on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(99) >= 11);
         end
      end
   end

   // check each accepted number
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_result(rsp_bus.value, rsp_bus.stop_offset);
   end

   // offer one byte, hold it until accepted; called and returns at a falling edge
   task automatic send_byte(input logic [CH_W-1:0] c, input logic first);
      while (!steady && $urandom_range(99) < 11) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.ch        <= c;
      req_bus.start_req <= first;
      do @(posedge clock); while (!req_bus.ready);
      board.note_byte(c, first);
      bytes_sent++;
      @(negedge clock);
   endtask

   // drop valid, let every number drain, then give the core time to settle
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_radix(input logic [BASE_W-1:0] b);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= b;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      board.set_radix(b);
      radix_writes++;
   endtask

   // send a string followed by one stop byte, start flag on the first byte
   task automatic send_text(input string s, input logic [CH_W-1:0] stop_byte);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == 0);
      send_byte(stop_byte, s.len() == 0);
   endtask

   function automatic logic [CH_W-1:0] digit_char(input int d);
      if (d < 10) return CH_W'(CHAR_ZERO + d);
      if ($urandom_range(1)) return CH_W'(CHAR_LO_A + d - 10);
      return CH_W'(CHAR_UP_A + d - 10);
   endfunction

   function automatic logic [CH_W-1:0] blank_char();
      if ($urandom_range(5) == 0) return CHAR_SPACE;
      return CH_W'(CHAR_TAB + $urandom_range(4));
   endfunction

   // build and send one conversion; returns the count of bytes that matter
   task automatic random_number(input logic [BASE_W-1:0] radix, output int used);
      logic [CH_W-1:0] text[$];
      int              digit_base;
      int              pick;
      digit_base = (radix == BASE_AUTO) ? 10 : radix;
      if (radix == BASE_ONE || radix > BASE_MAX) begin
         // invalid radix: the start byte alone ends it
         repeat ($urandom_range(1, 3)) text.push_back(8'($urandom));
      end else if ($urandom_range(99) < 10) begin
         // noise
         repeat ($urandom_range(1, 6)) text.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(99) < 30 ? $urandom_range(1, 3) : 0)
            text.push_back(blank_char());
         if ($urandom_range(2) == 0)
            text.push_back($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
         if ((radix == BASE_AUTO || radix == BASE_HEX) && $urandom_range(99) < 40) begin
            text.push_back(CHAR_ZERO);
            if ($urandom_range(1)) begin
               text.push_back($urandom_range(1) ? CHAR_LO_X : CHAR_UP_X);
               digit_base = 16;
            end else if (radix == BASE_AUTO) begin
               digit_base = 8;
            end
         end
         repeat ($urandom_range(99) < 15 ? $urandom_range(14, 24) : $urandom_range(0, 10))
            text.push_back(digit_char($urandom_range(digit_base - 1)));
         // break the sequence now and then
         if (text.size() > 0 && $urandom_range(99) < 8)
            text[$urandom_range(text.size() - 1)] = 8'($urandom);
         // stop byte; sometimes none so the next start abandons this one
         pick = $urandom_range(99);
         if (pick >= 12) begin
            if (pick < 50)
               text.push_back(8'h00);
            else if (pick < 75 && digit_base < 36)
               text.push_back(digit_char(digit_base));
            else
               text.push_back(8'($urandom));
         end
      end
      if (text.size() == 0) text.push_back(8'h00);
      foreach (text[i]) send_byte(text[i], i == 0);
      used = text.size();
      // trailing bytes the block should drop
      if ($urandom_range(99) < 20)
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
   endtask

   task automatic random_phase(input logic [BASE_W-1:0] radix, input int quota,
                               input bit calm, input bit stall_output);
      int done;
      int used;
      done = 0;
      write_radix(radix);
      steady = calm;
      if (stall_output) begin
         hold_request = 1'b1;
         @(negedge clock);
      end
      while (done < quota) begin
         random_number(radix, used);
         done += used;
      end
      steady = 1'b0;
   endtask

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.ch        = '0;
      req_bus.start_req = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed strings at the reset radix
      send_text(" \t-9", 8'h00);
      send_text("\v\f\r\n+", 8'hFF);
      send_text("", 8'h00);

      // automatic radix: hex, bare hex prefix, octal
      write_radix(BASE_AUTO);
      send_text("0x1F", "g");
      send_text("0X", "z");
      send_text("-017", "9");

      // widest radix, then binary
      write_radix(BASE_MAX);
      send_text("Zz", "!");
      write_radix(6'd2);
      send_text("-101", "2");

      // random streams over a range of radix settings
      random_phase(BASE_DEC, 70, 1'b0, 1'b0);
      random_phase(BASE_AUTO, 80, 1'b0, 1'b0);
      random_phase(BASE_HEX, 70, 1'b0, 1'b1);
      random_phase(6'd2, 60, 1'b0, 1'b0);
      random_phase(BASE_MAX, 60, 1'b1, 1'b0);
      random_phase(BASE_OCT, 60, 1'b0, 1'b0);
      random_phase(6'd37, 10, 1'b0, 1'b0);
      random_phase(6'd63, 10, 1'b0, 1'b0);
      random_phase(BASE_ONE, 8, 1'b0, 1'b0);
      random_phase(6'($urandom_range(3, 35)), 60, 1'b0, 1'b0);
      random_phase(BASE_AUTO, 60, 1'b0, 1'b0);

      wait_idle();
      $display("Covered %0d bytes and %0d numbers over %0d radix writes,",
               bytes_sent, board.numbers_checked, radix_writes);
      $display("with wrapping values, bad radix settings and one long result stall.");
      if (board.failures == 0 && board.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches", board.failures);
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ text_to_integer_parser.f @@
hdl/ttip_pkg.sv
hdl/ttip_req_if.sv
hdl/ttip_rsp_if.sv
hdl/ttip_in_stage.sv
hdl/ttip_core.sv
hdl/text_to_integer_parser.sv
tb/ttip_check_pkg.sv
tb/text_to_integer_parser_test.sv
